// ===== sv/pfd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfd_pkg
// Shared types and constants for the page framebuffer draw block.
// ----------------------------------------------------------------------------
package pfd_pkg;

   localparam logic [1:0] CMD_SET_PIXEL = 2'd0;
   localparam logic [1:0] CMD_FILL_RECT = 2'd1;
   localparam logic [1:0] CMD_READ_NEXT = 2'd2;

   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] x_start;
      logic [7:0] y_start;
      logic [7:0] x_end;
      logic [7:0] y_end;
   } req_type;

   typedef struct packed {
      logic [7:0] pixel_byte;
      logic [2:0] page_index;
      logic [6:0] column_index;
      logic       frame_last;
   } rsp_type;

   typedef enum logic {
      OP_DRAW = 1'b0,
      OP_READ = 1'b1
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] col_first;
      logic [7:0] col_last;
      logic [4:0] page_first;
      logic [4:0] page_last;
      logic [7:0] mask_first;
      logic [7:0] mask_last;
   } job_type;

   typedef struct packed {
      logic    valid;
      job_type job;
   } q_head_type;

   typedef struct packed {
      logic clearing;
   } back_status_type;

endpackage

// ===== sv/pfd_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfd_front
// Decodes an accepted transaction, clips it to the panel and builds a job.
// ----------------------------------------------------------------------------
module pfd_front import pfd_pkg::*; #(
   parameter int PANEL_WIDTH  = 128,
   parameter int PANEL_HEIGHT = 64
) (
   input  logic    accept,
   input  req_type req,
   output logic    push,
   output job_type job
);

   logic       x_in_panel;
   logic       y_in_panel;
   logic [7:0] x_end_clip;
   logic [7:0] y_end_clip;
   logic       box_ok;

   assign x_in_panel = {1'b0, req.x_start} < 9'(PANEL_WIDTH);
   assign y_in_panel = {1'b0, req.y_start} < 9'(PANEL_HEIGHT);
   assign x_end_clip = ({1'b0, req.x_end} >= 9'(PANEL_WIDTH)) ?
                       8'(PANEL_WIDTH - 1) : req.x_end;
   assign y_end_clip = ({1'b0, req.y_end} >= 9'(PANEL_HEIGHT)) ?
                       8'(PANEL_HEIGHT - 1) : req.y_end;
   assign box_ok     = (req.x_start <= req.x_end) && (req.y_start <= req.y_end) &&
                       x_in_panel && y_in_panel;

   always_comb begin
      push           = 1'b0;
      job.op         = OP_DRAW;
      job.col_first  = req.x_start;
      job.col_last   = req.x_start;
      job.page_first = req.y_start[7:3];
      job.page_last  = req.y_start[7:3];
      job.mask_first = 8'd1 << req.y_start[2:0];
      job.mask_last  = 8'd1 << req.y_start[2:0];
      case (req.cmd)
         CMD_SET_PIXEL: begin
            push = accept && x_in_panel && y_in_panel;
         end
         CMD_FILL_RECT: begin
            push           = accept && box_ok;
            job.col_last   = x_end_clip;
            job.page_last  = y_end_clip[7:3];
            job.mask_first = 8'hFF << req.y_start[2:0];
            job.mask_last  = 8'hFF >> (3'd7 - y_end_clip[2:0]);
         end
         CMD_READ_NEXT: begin
            push   = accept;
            job.op = OP_READ;
         end
         default: begin
            push = 1'b0;
         end
      endcase
   end

endmodule

// ===== sv/pfd_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfd_queue
// Short job queue between the front decoder and the memory engine.
// ----------------------------------------------------------------------------
module pfd_queue import pfd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  job_type    push_job,
   input  logic       pop,
   output logic       full,
   output q_head_type head
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   job_type            slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full       = count_ff == CNT_W'(QUEUE_DEPTH);
   assign head.valid = count_ff != '0;
   assign head.job   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ===== sv/pfd_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfd_back
// Frame store engine: clearing pass, read-modify-write walk and readout.
// ----------------------------------------------------------------------------
module pfd_back import pfd_pkg::*; #(
   parameter int PANEL_WIDTH  = 128,
   parameter int PANEL_HEIGHT = 64
) (
   input  logic            clock,
   input  logic            reset,
   input  q_head_type      head,
   output logic            pop,
   output back_status_type status,
   output logic            rsp_strobe,
   output rsp_type         rsp
);

   localparam int PAGES       = (PANEL_HEIGHT + 7) / 8;
   localparam int STORE_BYTES = PANEL_WIDTH * PAGES;
   localparam int AW          = $clog2(STORE_BYTES);

   typedef enum logic [2:0] {
      ST_CLEAR = 3'b001,
      ST_IDLE  = 3'b010,
      ST_WORK  = 3'b100
   } state_type;

   logic [7:0]    mem [STORE_BYTES];
   logic [7:0]    rd_data_ff;

   state_type     state_ff, state_in;
   logic [AW-1:0] clr_addr_ff, clr_addr_in;
   job_type       job_ff, job_in;
   logic [4:0]    page_ff, page_in;
   logic [7:0]    col_ff, col_in;
   logic [AW-1:0] addr_ff;
   logic [4:0]    rptr_page_ff, rptr_page_in;
   logic [7:0]    rptr_col_ff, rptr_col_in;
   logic          rsp_strobe_ff, rsp_strobe_in;
   rsp_type       rsp_ff, rsp_in;

   logic          col_end;
   logic          page_end;
   logic          walk_done;
   logic          frame_end;
   logic [4:0]    sel_page;
   logic [7:0]    sel_col;
   logic [AW-1:0] sel_addr;
   logic [7:0]    mask;
   logic          we;
   logic [AW-1:0] waddr;
   logic [7:0]    wdata;

   assign col_end   = col_ff == job_ff.col_last;
   assign page_end  = page_ff == job_ff.page_last;
   assign walk_done = (job_ff.op == OP_READ) || (col_end && page_end);
   assign frame_end = (page_ff == 5'(PAGES - 1)) && (col_ff == 8'(PANEL_WIDTH - 1));
   assign mask      = ((page_ff == job_ff.page_first) ? job_ff.mask_first : 8'hFF) &
                      (page_end ? job_ff.mask_last : 8'hFF);
   assign sel_addr  = AW'(AW'(sel_page) * AW'(PANEL_WIDTH)) + AW'(sel_col);

   assign pop        = (state_ff == ST_IDLE) && head.valid;
   assign status     = '{clearing: state_ff == ST_CLEAR};
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp        = rsp_ff;

   always_comb begin
      if (state_ff == ST_IDLE) begin
         sel_page = (head.job.op == OP_READ) ? rptr_page_ff : head.job.page_first;
         sel_col  = (head.job.op == OP_READ) ? rptr_col_ff : head.job.col_first;
      end else begin
         sel_page = col_end ? page_ff + 1'b1 : page_ff;
         sel_col  = col_end ? job_ff.col_first : col_ff + 1'b1;
      end
   end

   always_comb begin
      state_in      = state_ff;
      clr_addr_in   = clr_addr_ff;
      job_in        = job_ff;
      page_in       = page_ff;
      col_in        = col_ff;
      rptr_page_in  = rptr_page_ff;
      rptr_col_in   = rptr_col_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      we            = 1'b0;
      waddr         = addr_ff;
      wdata         = '0;
      case (state_ff)
         ST_CLEAR: begin
            we          = 1'b1;
            waddr       = clr_addr_ff;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == AW'(STORE_BYTES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (head.valid) begin
               job_in   = head.job;
               page_in  = sel_page;
               col_in   = sel_col;
               state_in = ST_WORK;
            end
         end
         ST_WORK: begin
            we = 1'b1;
            if (job_ff.op == OP_READ) begin
               wdata                = '0;
               rsp_strobe_in        = 1'b1;
               rsp_in.pixel_byte    = rd_data_ff;
               rsp_in.page_index    = 3'(page_ff);
               rsp_in.column_index  = 7'(col_ff);
               rsp_in.frame_last    = frame_end;
               if (frame_end) begin
                  rptr_page_in = '0;
                  rptr_col_in  = '0;
               end else if (col_ff == 8'(PANEL_WIDTH - 1)) begin
                  rptr_page_in = page_ff + 1'b1;
                  rptr_col_in  = '0;
               end else begin
                  rptr_page_in = page_ff;
                  rptr_col_in  = col_ff + 1'b1;
               end
            end else begin
               wdata = rd_data_ff | mask;
            end
            if (walk_done) begin
               state_in = ST_IDLE;
            end else begin
               page_in = sel_page;
               col_in  = sel_col;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_addr_ff   <= '0;
         rptr_page_ff  <= '0;
         rptr_col_ff   <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_addr_ff   <= clr_addr_in;
         rptr_page_ff  <= rptr_page_in;
         rptr_col_ff   <= rptr_col_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff  <= job_in;
      page_ff <= page_in;
      col_ff  <= col_in;
      addr_ff <= sel_addr;
      rsp_ff  <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rd_data_ff <= mem[sel_addr];
   end

endmodule

// ===== sv/page_framebuffer_draw.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_framebuffer_draw
// Page-organized monochrome frame store with pixel set, rectangle fill and
// a read-and-clear readout in page-then-column order.
// ----------------------------------------------------------------------------
// Channel    Ports                          Handshake
// request    start, busy, req_payload       taken when start is high, busy low
// response   rsp_strobe, rsp_payload        valid for one cycle, always taken
//
// After reset a clearing pass writes zero to all PANEL_WIDTH times page count
// bytes (1024 at the default size), with busy held high.
// A pixel set or a byte read makes one memory read, then one write in the
// memory engine; the registered response appears in the cycle after the write.
// A rectangle fill reads the first byte, then writes each byte touched while
// reading the next, through the single write port of the frame store.
// Two jobs queue between the decoder and the engine; busy rises when full.
// ----------------------------------------------------------------------------
module page_framebuffer_draw import pfd_pkg::*; #(
   parameter int PANEL_WIDTH  = 128,
   parameter int PANEL_HEIGHT = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_payload,
   output logic    rsp_strobe,
   output rsp_type rsp_payload
);

   logic            accept;
   logic            push;
   job_type         push_job;
   logic            pop;
   logic            q_full;
   q_head_type      head;
   back_status_type status;

   assign busy   = status.clearing || q_full;
   assign accept = start && !busy;

   pfd_front #(
      .PANEL_WIDTH  (PANEL_WIDTH),
      .PANEL_HEIGHT (PANEL_HEIGHT)
   ) u_front (
      .accept (accept),
      .req    (req_payload),
      .push   (push),
      .job    (push_job)
   );

   pfd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .full     (q_full),
      .head     (head)
   );

   pfd_back #(
      .PANEL_WIDTH  (PANEL_WIDTH),
      .PANEL_HEIGHT (PANEL_HEIGHT)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .pop        (pop),
      .status     (status),
      .rsp_strobe (rsp_strobe),
      .rsp        (rsp_payload)
   );

   a_no_rsp_while_clearing: assert property (@(posedge clock) disable iff (reset)
      status.clearing |-> !rsp_strobe)
      else $error("Response issued during the clearing pass.");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_full)
      else $error("Job queue overflow.");

   a_last_at_final_column: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_payload.frame_last) |->
         (rsp_payload.column_index == 7'(PANEL_WIDTH - 1)))
      else $error("Frame end flagged away from the final column.");

   a_pop_only_with_job: assert property (@(posedge clock) disable iff (reset)
      pop |-> head.valid && !status.clearing)
      else $error("Engine took a job from an empty queue.");

endmodule
